// ===== hw/rtl/oac_pkg.sv =====
// ----------------------------------------------------------------------------
// oac_pkg
// Shared types and constants for the orientation align controller: register
// indexes, fixed-point angle constants and the configuration bundle.
// ----------------------------------------------------------------------------
package oac_pkg;

  // angle constants, Q3.12 radians, carried at turn width
  localparam int TURN_W = 17;
  localparam logic signed [TURN_W-1:0] PI_Q     = 17'sd12868;
  localparam logic signed [TURN_W-1:0] TWO_PI_Q = 17'sd25736;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SATISFACTION_ANGLE = 3'd0,
    REG_SLOW_ANGLE         = 3'd1,
    REG_INV_SLOW_ANGLE     = 3'd2,
    REG_MAX_ANGULAR_SPEED  = 3'd3,
    REG_INV_TIME_TO_TARGET = 3'd4,
    REG_MAX_ANGULAR_ACCEL  = 3'd5
  } cfg_idx_t;

  // live register values handed to the datapath
  typedef struct packed {
    logic [13:0] satisfaction_angle;
    logic [13:0] slow_angle;
    logic [15:0] inv_slow_angle;
    logic [14:0] max_angular_speed;
    logic [15:0] inv_time_to_target;
    logic [14:0] max_angular_accel;
  } cfg_t;

endpackage

// ===== hw/rtl/orientation_align_controller_core.sv =====
// ----------------------------------------------------------------------------
// orientation_align_controller_core
// Align steering: turns a heading error and present angular speed into a
// clamped angular acceleration command or a stop indication.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_target_heading, in_current_heading, in_current_speed and
//   raise start; the transfer happens at each edge with start high and busy
//   low. busy stays low, so a new item may be given on every cycle.
//   Result: out_valid pulses for one cycle with out_stop_rotation and
//   out_angular_accel; it must be taken in that cycle, there is no stall.
//   Pipeline: the result leaves a seven-register pipeline, so throughput is
//   one item per cycle; the two-multiply chain for the slow zone and the
//   acceleration multiply each get their own stage.
//   Configuration: cfg_we, cfg_index, cfg_wdata write one register per edge;
//   write only while no item is in flight. Unknown indexes are ignored.
//   Reset: synchronous on rst_n low; empties the pipeline (no strobes) and
//   loads the register defaults.
// ----------------------------------------------------------------------------
module orientation_align_controller_core import oac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  logic signed [14:0]    in_target_heading,
  input  logic signed [14:0]    in_current_heading,
  input  logic signed [15:0]    in_current_speed,
  // result channel
  output logic                  out_valid,
  output logic                  out_stop_rotation,
  output logic signed [15:0]    out_angular_accel,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic in_xfer;

  // register write decode, values masked to register width
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SATISFACTION_ANGLE: cfg_nxt.satisfaction_angle = cfg_wdata[13:0];
        REG_SLOW_ANGLE:         cfg_nxt.slow_angle         = cfg_wdata[13:0];
        REG_INV_SLOW_ANGLE:     cfg_nxt.inv_slow_angle     = cfg_wdata[15:0];
        REG_MAX_ANGULAR_SPEED:  cfg_nxt.max_angular_speed  = cfg_wdata[14:0];
        REG_INV_TIME_TO_TARGET: cfg_nxt.inv_time_to_target = cfg_wdata[15:0];
        REG_MAX_ANGULAR_ACCEL:  cfg_nxt.max_angular_accel  = cfg_wdata[14:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  // configuration registers with defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.satisfaction_angle <= 14'd72;
      cfg_r.slow_angle         <= 14'd2048;
      cfg_r.inv_slow_angle     <= 16'd512;
      cfg_r.max_angular_speed  <= 15'd768;
      cfg_r.inv_time_to_target <= 16'd2560;
      cfg_r.max_angular_accel  <= 15'd1280;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline never backs up, so the input side is always open
  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  oac_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_xfer),
    .in_target_heading (in_target_heading),
    .in_current_heading(in_current_heading),
    .in_current_speed  (in_current_speed),
    .cfg               (cfg_r),
    .out_valid         (out_valid),
    .out_stop_rotation (out_stop_rotation),
    .out_angular_accel (out_angular_accel)
  );

endmodule

// ===== hw/rtl/oac_datapath.sv =====
// ----------------------------------------------------------------------------
// oac_datapath
// Seven-stage pipeline: turn wrap, zone compare with first multiply, second
// multiply, wanted speed, speed error, acceleration multiply, round and clamp.
// ----------------------------------------------------------------------------
module oac_datapath import oac_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [14:0] in_target_heading,
  input  logic signed [14:0] in_current_heading,
  input  logic signed [15:0] in_current_speed,
  input  cfg_t               cfg,
  output logic               out_valid,
  output logic               out_stop_rotation,
  output logic signed [15:0] out_angular_accel
);

  // stage valid bits
  logic [5:0] vld_r;
  logic       out_valid_r;

  // stage 1: wrapped turn as sign and magnitude
  logic signed [TURN_W-1:0] diff;
  logic signed [TURN_W-1:0] wrap_hi;
  logic signed [TURN_W-1:0] wrap_lo;
  logic signed [TURN_W-1:0] turn_abs;
  logic                     s1_neg_r;
  logic [13:0]              s1_mag_r;
  logic signed [15:0]       s1_spd_r;

  // stage 2: zone flags and first product
  logic                     s2_neg_r;
  logic                     s2_stop_r;
  logic                     s2_slow_r;
  logic [28:0]              s2_p1_r;
  logic signed [15:0]       s2_spd_r;

  // stage 3: full slow-zone product
  logic                     s3_neg_r;
  logic                     s3_stop_r;
  logic                     s3_slow_r;
  logic [44:0]              s3_p2_r;
  logic signed [15:0]       s3_spd_r;

  // stage 4: wanted speed
  logic [45:0]              ws_sum;
  logic [25:0]              ws_rnd;
  logic [14:0]              ws_mag;
  logic signed [15:0]       s4_wanted_r;
  logic                     s4_stop_r;
  logic signed [15:0]       s4_spd_r;

  // stage 5: speed error as sign and magnitude
  logic signed [17:0]       delta;
  logic signed [17:0]       delta_abs;
  logic                     s5_stop_r;
  logic                     s5_neg_r;
  logic [16:0]              s5_mag_r;

  // stage 6: acceleration product
  logic                     s6_stop_r;
  logic                     s6_neg_r;
  logic [32:0]              s6_p3_r;

  // output stage
  logic [33:0]              ac_sum;
  logic [25:0]              ac_rnd;
  logic [14:0]              ac_mag;
  logic signed [15:0]       ac_val;
  logic                     out_stop_r;
  logic signed [15:0]       out_accel_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[4:0], in_valid};
      out_valid_r <= vld_r[5];
    end
  end

  // shortest turn, wrapped once each way by two pi
  always_comb begin
    diff     = {{2{in_target_heading[14]}}, in_target_heading}
             - {{2{in_current_heading[14]}}, in_current_heading};
    wrap_hi  = (diff > PI_Q) ? diff - TWO_PI_Q : diff;
    wrap_lo  = (wrap_hi <= -PI_Q) ? wrap_hi + TWO_PI_Q : wrap_hi;
    turn_abs = wrap_lo[TURN_W-1] ? -wrap_lo : wrap_lo;
  end

  always_ff @(posedge clk) begin
    s1_neg_r <= wrap_lo[TURN_W-1];
    s1_mag_r <= turn_abs[13:0];
    s1_spd_r <= in_current_speed;
  end

  // zone compares and turn times max speed
  always_ff @(posedge clk) begin
    s2_neg_r  <= s1_neg_r;
    s2_stop_r <= s1_mag_r < cfg.satisfaction_angle;
    s2_slow_r <= s1_mag_r < cfg.slow_angle;
    s2_p1_r   <= 29'(s1_mag_r) * 29'(cfg.max_angular_speed);
    s2_spd_r  <= s1_spd_r;
  end

  // times reciprocal of slow angle
  always_ff @(posedge clk) begin
    s3_neg_r  <= s2_neg_r;
    s3_stop_r <= s2_stop_r;
    s3_slow_r <= s2_slow_r;
    s3_p2_r   <= 45'(s2_p1_r) * 45'(cfg.inv_slow_angle);
    s3_spd_r  <= s2_spd_r;
  end

  // round magnitude to Q7.8, limit to max speed (max speed outside slow zone), restore sign
  always_comb begin
    ws_sum = 46'(s3_p2_r) + 46'd524288;
    ws_rnd = ws_sum[45:20];
    if (!s3_slow_r) begin
      ws_mag = cfg.max_angular_speed;
    end else if (ws_rnd > 26'(cfg.max_angular_speed)) begin
      ws_mag = cfg.max_angular_speed;
    end else begin
      ws_mag = ws_rnd[14:0];
    end
  end

  always_ff @(posedge clk) begin
    s4_wanted_r <= s3_neg_r ? -$signed({1'b0, ws_mag}) : $signed({1'b0, ws_mag});
    s4_stop_r   <= s3_stop_r;
    s4_spd_r    <= s3_spd_r;
  end

  // speed error
  always_comb begin
    delta     = {{2{s4_wanted_r[15]}}, s4_wanted_r} - {{2{s4_spd_r[15]}}, s4_spd_r};
    delta_abs = delta[17] ? -delta : delta;
  end

  always_ff @(posedge clk) begin
    s5_stop_r <= s4_stop_r;
    s5_neg_r  <= delta[17];
    s5_mag_r  <= delta_abs[16:0];
  end

  // error times reciprocal of time to target
  always_ff @(posedge clk) begin
    s6_stop_r <= s5_stop_r;
    s6_neg_r  <= s5_neg_r;
    s6_p3_r   <= 33'(s5_mag_r) * 33'(cfg.inv_time_to_target);
  end

  // round to Q7.8, clamp to max accel, zero when stopping
  always_comb begin
    ac_sum = 34'(s6_p3_r) + 34'd128;
    ac_rnd = ac_sum[33:8];
    ac_mag = (ac_rnd > 26'(cfg.max_angular_accel)) ? cfg.max_angular_accel
                                                    : ac_rnd[14:0];
    if (s6_stop_r) begin
      ac_val = '0;
    end else if (s6_neg_r) begin
      ac_val = -$signed({1'b0, ac_mag});
    end else begin
      ac_val = $signed({1'b0, ac_mag});
    end
  end

  always_ff @(posedge clk) begin
    out_stop_r  <= s6_stop_r;
    out_accel_r <= ac_val;
  end

  assign out_valid         = out_valid_r;
  assign out_stop_rotation = out_stop_r;
  assign out_angular_accel = out_accel_r;

endmodule
